### hdl/sfnms_pkg.sv
// ---------------------------------------------------------------------------
// sfnms_pkg
// Types and constants shared by the score filter and suppression block.
// ---------------------------------------------------------------------------
package sfnms_pkg;

    typedef struct packed {
        logic [15:0] score_class0;
        logic [15:0] score_class1;
        logic [15:0] box_left;
        logic [15:0] box_top;
        logic [15:0] box_right;
        logic [15:0] box_bottom;
        logic        frame_end;
    } in_item_t;

    typedef struct packed {
        logic [15:0] kept_left;
        logic [15:0] kept_top;
        logic [15:0] kept_right;
        logic [15:0] kept_bottom;
        logic [15:0] kept_score;
        logic        final_box;
        logic        no_box;
        logic        dropped_some;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_NMS_I,
        ST_NMS_RDI,
        ST_NMS_J,
        ST_NMS_RDJ,
        ST_IOU_A,
        ST_IOU_B,
        ST_EMIT,
        ST_EMPTY,
        ST_DRAIN
    } state_t;

    localparam logic [1:0] REG_SCORE_THR = 2'd0;
    localparam logic [1:0] REG_IOU_THR   = 2'd1;
    localparam logic [1:0] REG_CLASS     = 2'd2;

    localparam logic [15:0] RST_SCORE_THR = 16'd32768;
    localparam logic [15:0] RST_IOU_THR   = 16'd32768;

endpackage

### hdl/sfnms_iou.sv
// ---------------------------------------------------------------------------
// sfnms_iou
// Pipelined overlap test: stage one forms spans, stage two the intersection
// and box areas; the union and the cross-multiplied compare against the
// threshold follow combinationally on the registered stage-two values.
// ---------------------------------------------------------------------------
module sfnms_iou
(
    input  logic        clk,
    input  logic [63:0] box_a,
    input  logic [63:0] box_b,
    input  logic [15:0] ovl_limit,
    output logic        overlap
);

    logic [15:0] iw_reg, ih_reg, aw_reg, ah_reg, bw_reg, bh_reg;
    logic [15:0] iw_next, ih_next, aw_next, ah_next, bw_next, bh_next;
    logic [31:0] inter_reg, area_a_reg, area_b_reg;
    logic [31:0] inter_next, area_a_next, area_b_next;
    logic [33:0] uni;
    logic [49:0] lhs, rhs;

    function automatic logic [15:0] span(input logic [15:0] lo, input logic [15:0] hi);
        span = (hi > lo) ? (hi - lo) : 16'd0;
    endfunction

    function automatic logic [15:0] max16(input logic [15:0] a, input logic [15:0] b);
        max16 = (a > b) ? a : b;
    endfunction

    function automatic logic [15:0] min16(input logic [15:0] a, input logic [15:0] b);
        min16 = (a < b) ? a : b;
    endfunction

    // form clamped spans
    always_comb
    begin
        iw_next = span(max16(box_a[15:0], box_b[15:0]), min16(box_a[47:32], box_b[47:32]));
        ih_next = span(max16(box_a[31:16], box_b[31:16]), min16(box_a[63:48], box_b[63:48]));
        aw_next = span(box_a[15:0], box_a[47:32]);
        ah_next = span(box_a[31:16], box_a[63:48]);
        bw_next = span(box_b[15:0], box_b[47:32]);
        bh_next = span(box_b[31:16], box_b[63:48]);
    end

    // form intersection and areas
    always_comb
    begin
        inter_next  = {16'd0, iw_reg} * {16'd0, ih_reg};
        area_a_next = {16'd0, aw_reg} * {16'd0, ah_reg};
        area_b_next = {16'd0, bw_reg} * {16'd0, bh_reg};
    end

    always_ff @(posedge clk)
    begin
        iw_reg     <= iw_next;
        ih_reg     <= ih_next;
        aw_reg     <= aw_next;
        ah_reg     <= ah_next;
        bw_reg     <= bw_next;
        bh_reg     <= bh_next;
        inter_reg  <= inter_next;
        area_a_reg <= area_a_next;
        area_b_reg <= area_b_next;
    end

    // compare intersection against threshold times union
    always_comb
    begin
        uni     = {2'b0, area_a_reg} + {2'b0, area_b_reg} - {2'b0, inter_reg};
        lhs     = {2'b0, inter_reg, 16'd0};
        rhs     = {16'd0, uni} * {34'd0, ovl_limit};
        overlap = (uni != 34'd0) && (lhs > rhs);
    end

endmodule

### hdl/score_filter_nms_core.sv
// ---------------------------------------------------------------------------
// score_filter_nms_core
// Score filter, sorted candidate store and greedy non-maximum suppression.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | sfnms_pkg::in_item_t
//  out     | output    | out_valid/out_stall | sfnms_pkg::out_item_t
//  cfg     | input     | APB psel/penable    | 16-bit and 1-bit registers
//
// Insertion stalls the input while the entries below the new score move down
// (at most count of them); each move waits for the registered read in ST_SCAN
// and writes the entry one slot further on in ST_SHIFT. A filtered-out anchor
// stalls nothing unless it ends the frame. Suppression walks the store with a
// pair loop; each unsuppressed pair passes through ST_NMS_RDJ, ST_IOU_A and
// ST_IOU_B and the shared pipelined overlap unit; each result waits on out_stall.
// Reset clears control state; the store needs no clearing.
// ---------------------------------------------------------------------------
module score_filter_nms_core
#(
    parameter int MAX_CANDIDATES = 64,
    parameter int COORD_BITS     = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sfnms_pkg::in_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output sfnms_pkg::out_item_t  out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW = $clog2(MAX_CANDIDATES);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] MAXC = CW'(MAX_CANDIDATES);

    sfnms_pkg::state_t state_reg, state_next;

    logic [15:0] score_thr_reg, iou_thr_reg;
    logic        class_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic          ovf_reg, ovf_next;
    logic          last_reg, last_next;
    logic [MAX_CANDIDATES-1:0] sup_reg, sup_next;

    logic [15:0] new_score_reg, new_score_next;
    logic [63:0] new_box_reg, new_box_next;
    logic [63:0] box_i_reg, box_i_next;
    logic [15:0] score_i_reg, score_i_next;

    logic        out_valid_reg, out_valid_next;
    sfnms_pkg::out_item_t out_reg, out_next;

    // memory
    logic [79:0] mem [MAX_CANDIDATES];
    logic [79:0] rd_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [79:0]   wr_data;
    logic          wr_en;

    logic        overlap;
    logic        in_acc;
    logic [15:0] sel_score;
    logic [63:0] in_box;
    logic [15:0] cmask;
    logic        cfg_wr;

    assign in_stall  = (state_reg != sfnms_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign cmask     = 16'((32'd1 << COORD_BITS) - 1);
    assign sel_score = class_reg ? in_data.score_class1 : in_data.score_class0;
    assign in_box    = {in_data.box_bottom & cmask, in_data.box_right & cmask,
                        in_data.box_top & cmask, in_data.box_left & cmask};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_thr_reg <= sfnms_pkg::RST_SCORE_THR;
            iou_thr_reg   <= sfnms_pkg::RST_IOU_THR;
            class_reg     <= 1'b1;
        end
        else if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            if (paddr[3:2] == sfnms_pkg::REG_SCORE_THR)
                score_thr_reg <= pwdata[15:0];
            else if (paddr[3:2] == sfnms_pkg::REG_IOU_THR)
                iou_thr_reg <= pwdata[15:0];
            else if (paddr[3:2] == sfnms_pkg::REG_CLASS)
                class_reg <= pwdata[0];
        end
    end

    // read back
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[3:2] == sfnms_pkg::REG_SCORE_THR)
            prdata = {16'd0, score_thr_reg};
        else if (paddr[3:2] == sfnms_pkg::REG_IOU_THR)
            prdata = {16'd0, iou_thr_reg};
        else if (paddr[3:2] == sfnms_pkg::REG_CLASS)
            prdata = {31'd0, class_reg};
    end

    // candidate store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    sfnms_iou u_iou
    (
        .clk       (clk),
        .box_a     (box_i_reg),
        .box_b     (rd_reg[63:0]),
        .ovl_limit (iou_thr_reg),
        .overlap   (overlap)
    );

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfnms_pkg::ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            sup_reg       <= '0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            sup_reg       <= sup_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_score_reg <= new_score_next;
        new_box_reg   <= new_box_next;
        box_i_reg     <= box_i_next;
        score_i_reg   <= score_i_next;
        out_reg       <= out_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        sup_next       = sup_reg;
        pos_next       = pos_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        last_next      = last_reg;
        new_score_next = new_score_reg;
        new_box_next   = new_box_reg;
        box_i_next     = box_i_reg;
        score_i_next   = score_i_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        rd_addr        = pos_reg[AW-1:0] - AW'(1);
        wr_addr        = pos_reg[AW-1:0];
        wr_data        = {new_score_reg, new_box_reg};
        wr_en          = 1'b0;

        unique case (state_reg)
            sfnms_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    new_score_next = sel_score;
                    new_box_next   = in_box;
                    last_next      = in_data.frame_end;
                    if (sel_score > score_thr_reg)
                    begin
                        // start one past the last entry; a full store drops its tail
                        pos_next = count_reg;
                        rd_addr  = count_reg[AW-1:0] - AW'(1);
                        if (count_reg == MAXC)
                            ovf_next = 1'b1;
                        else
                            count_next = count_reg + CW'(1);
                        state_next = sfnms_pkg::ST_SCAN;
                    end
                    else if (in_data.frame_end)
                    begin
                        i_next     = '0;
                        state_next = sfnms_pkg::ST_NMS_I;
                    end
                end
            end

            sfnms_pkg::ST_SCAN:
            begin
                // wait for the registered read of entry pos-1
                state_next = sfnms_pkg::ST_SHIFT;
            end

            sfnms_pkg::ST_SHIFT:
            begin
                // rd_reg holds entry pos-1; the slot past the end is never written
                if (pos_reg != '0 && rd_reg[79:64] < new_score_reg)
                begin
                    wr_en    = (pos_reg != MAXC);
                    wr_data  = rd_reg;
                    pos_next = pos_reg - CW'(1);
                    rd_addr  = pos_reg[AW-1:0] - AW'(2);
                    state_next = sfnms_pkg::ST_SCAN;
                end
                else
                begin
                    // full store whose tail stays: new anchor dropped
                    if (pos_reg != MAXC)
                        wr_en = 1'b1;
                    if (last_reg)
                    begin
                        i_next     = '0;
                        state_next = sfnms_pkg::ST_NMS_I;
                    end
                    else
                        state_next = sfnms_pkg::ST_IDLE;
                end
            end

            sfnms_pkg::ST_NMS_I:
            begin
                rd_addr = i_reg[AW-1:0];
                if (count_reg == '0)
                    state_next = sfnms_pkg::ST_EMPTY;
                else if (i_reg >= count_reg)
                    state_next = sfnms_pkg::ST_DRAIN;
                else if (sup_reg[i_reg[AW-1:0]])
                    i_next = i_reg + CW'(1);
                else
                    state_next = sfnms_pkg::ST_NMS_RDI;
            end

            sfnms_pkg::ST_NMS_RDI:
            begin
                box_i_next   = rd_reg[63:0];
                score_i_next = rd_reg[79:64];
                j_next       = i_reg + CW'(1);
                state_next   = sfnms_pkg::ST_NMS_J;
            end

            sfnms_pkg::ST_NMS_J:
            begin
                rd_addr = j_reg[AW-1:0];
                if (j_reg >= count_reg)
                    state_next = sfnms_pkg::ST_EMIT;
                else if (sup_reg[j_reg[AW-1:0]])
                    j_next = j_reg + CW'(1);
                else
                    state_next = sfnms_pkg::ST_NMS_RDJ;
            end

            sfnms_pkg::ST_NMS_RDJ:
                state_next = sfnms_pkg::ST_IOU_A;

            sfnms_pkg::ST_IOU_A:
                state_next = sfnms_pkg::ST_IOU_B;

            sfnms_pkg::ST_IOU_B:
            begin
                if (overlap)
                    sup_next[j_reg[AW-1:0]] = 1'b1;
                j_next     = j_reg + CW'(1);
                state_next = sfnms_pkg::ST_NMS_J;
            end

            sfnms_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next        = 1'b1;
                    out_next.kept_left    = box_i_reg[15:0];
                    out_next.kept_top     = box_i_reg[31:16];
                    out_next.kept_right   = box_i_reg[47:32];
                    out_next.kept_bottom  = box_i_reg[63:48];
                    out_next.kept_score   = score_i_reg;
                    out_next.no_box       = 1'b0;
                    out_next.dropped_some = ovf_reg;
                    out_next.final_box    = 1'b1;
                    // final unless a later unsuppressed entry exists
                    for (int k = 0; k < MAX_CANDIDATES; k++)
                        if (CW'(k) > i_reg && CW'(k) < count_reg && !sup_reg[k])
                            out_next.final_box = 1'b0;
                    i_next     = i_reg + CW'(1);
                    state_next = sfnms_pkg::ST_NMS_I;
                end
            end

            sfnms_pkg::ST_EMPTY:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.final_box = 1'b1;
                    out_next.no_box    = 1'b1;
                    state_next     = sfnms_pkg::ST_DRAIN;
                end
            end

            sfnms_pkg::ST_DRAIN:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                sup_next   = '0;
                state_next = sfnms_pkg::ST_IDLE;
            end

            default:
                state_next = sfnms_pkg::ST_IDLE;
        endcase
    end

    // store never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= MAXC)
        else $error("entry count above capacity");
    // no input taken while the sequencer is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sfnms_pkg::ST_IDLE) |-> in_stall)
        else $error("input accepted while busy");
    // a frame ends with the store emptied
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfnms_pkg::ST_DRAIN) |=> (count_reg == '0 && !ovf_reg))
        else $error("store not cleared after frame");

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Drives anchor frames through the score filter and suppression block and
// checks every kept box against a predictor of the sorted store and the
// greedy overlap suppression, across several register settings.
// ---------------------------------------------------------------------------
class nms_scoreboard;
    sfnms_pkg::out_item_t kept_q[$];
    logic [15:0] score_thr;
    logic [15:0] iou_thr;
    logic        cls_sel;
    logic [15:0] st_score[64];
    logic [63:0] st_box[64];
    int          st_count;
    bit          st_over;
    int          mismatches;

    function new();
        score_thr  = sfnms_pkg::RST_SCORE_THR;
        iou_thr    = sfnms_pkg::RST_IOU_THR;
        cls_sel    = 1'b1;
        st_count   = 0;
        st_over    = 1'b0;
        mismatches = 0;
    endfunction

    function longint unsigned span(longint unsigned lo, longint unsigned hi);
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function bit too_close(logic [63:0] a, logic [63:0] b);
        longint unsigned l, t, r, d, inter, ua, ub, uni;
        l = 64'((a[15:0] > b[15:0]) ? a[15:0] : b[15:0]);
        t = 64'((a[31:16] > b[31:16]) ? a[31:16] : b[31:16]);
        r = 64'((a[47:32] < b[47:32]) ? a[47:32] : b[47:32]);
        d = 64'((a[63:48] < b[63:48]) ? a[63:48] : b[63:48]);
        inter = span(l, r) * span(t, d);
        ua = span(64'(a[15:0]), 64'(a[47:32])) * span(64'(a[31:16]), 64'(a[63:48]));
        ub = span(64'(b[15:0]), 64'(b[47:32])) * span(64'(b[31:16]), 64'(b[63:48]));
        uni = ua + ub - inter;
        if (uni == 0)
            return 0;
        return (inter << 16) > longint'(iou_thr) * uni;
    endfunction

    // Note an accepted anchor: filter, insert sorted, run suppression on frame end
    function void note_anchor(sfnms_pkg::in_item_t it);
        logic [15:0] sc;
        logic [63:0] bx;
        int pos, i, j, last;
        bit gone[64];
        sfnms_pkg::out_item_t o;
        sc = cls_sel ? it.score_class1 : it.score_class0;
        bx = {it.box_bottom, it.box_right, it.box_top, it.box_left};
        if (sc > score_thr) begin
            pos = st_count;
            while (pos > 0 && st_score[pos-1] < sc)
                pos--;
            if (st_count >= 64) begin
                st_over = 1'b1;
                i = (pos >= 64) ? -1 : 63;
            end else begin
                i = st_count;
                st_count++;
            end
            if (i >= 0) begin
                for (; i > pos; i--) begin
                    st_score[i] = st_score[i-1];
                    st_box[i]   = st_box[i-1];
                end
                st_score[pos] = sc;
                st_box[pos]   = bx;
            end
        end
        if (!it.frame_end)
            return;
        if (st_count == 0) begin
            o = '0;
            o.final_box = 1'b1;
            o.no_box = 1'b1;
            kept_q = {kept_q, o};
        end else begin
            for (i = 0; i < 64; i++)
                gone[i] = 1'b0;
            last = kept_q.size();
            for (i = 0; i < st_count; i++) begin
                if (gone[i])
                    continue;
                for (j = i + 1; j < st_count; j++)
                    if (!gone[j] && too_close(st_box[i], st_box[j]))
                        gone[j] = 1'b1;
                o = '0;
                o.kept_left    = st_box[i][15:0];
                o.kept_top     = st_box[i][31:16];
                o.kept_right   = st_box[i][47:32];
                o.kept_bottom  = st_box[i][63:48];
                o.kept_score   = st_score[i];
                o.dropped_some = st_over;
                kept_q = {kept_q, o};
            end
            kept_q[kept_q.size()-1].final_box = 1'b1;
        end
        st_count = 0;
        st_over  = 1'b0;
    endfunction

    function void report(string what, logic [15:0] got, logic [15:0] want);
        mismatches++;
        $display("mismatch %s: got %0h expected %0h", what, got, want);
    endfunction

    // Check one result against the oldest expected kept box
    function void check_kept(sfnms_pkg::out_item_t g);
        sfnms_pkg::out_item_t w;
        if (kept_q.size() == 0) begin
            report("unexpected result", g.kept_score, 16'd0);
            return;
        end
        w = kept_q.pop_front();
        if (g.kept_left    !== w.kept_left)    report("kept_left", g.kept_left, w.kept_left);
        if (g.kept_top     !== w.kept_top)     report("kept_top", g.kept_top, w.kept_top);
        if (g.kept_right   !== w.kept_right)   report("kept_right", g.kept_right, w.kept_right);
        if (g.kept_bottom  !== w.kept_bottom)  report("kept_bottom", g.kept_bottom, w.kept_bottom);
        if (g.kept_score   !== w.kept_score)   report("kept_score", g.kept_score, w.kept_score);
        if (g.final_box    !== w.final_box)
            report("final_box", 16'(g.final_box), 16'(w.final_box));
        if (g.no_box       !== w.no_box)
            report("no_box", 16'(g.no_box), 16'(w.no_box));
        if (g.dropped_some !== w.dropped_some)
            report("dropped_some", 16'(g.dropped_some), 16'(w.dropped_some));
    endfunction
endclass

module tb_top;

    localparam int IDLE_LIMIT = 200000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    sfnms_pkg::in_item_t  in_data;
    logic                 out_valid;
    logic                 out_stall;
    sfnms_pkg::out_item_t out_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [3:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    nms_scoreboard sb;
    int  idle_cycles = 0;
    bit  hold_off;
    bit  no_gaps;

    score_filter_nms_core uut (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Count cycles without any transaction; give up at the limit
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Check accepted results
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_kept(out_data);
    end

    // Receiver: random stall per result, long hold-off when asked
    initial
    begin : receiver
        int w;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_stall <= 1'b1;
            end else if (out_valid && !out_stall) begin
                w = no_gaps ? 0 : int'($urandom_range(0, 15));
                if (w > 0) begin
                    out_stall <= 1'b1;
                    repeat (w) @(posedge clk);
                end
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sfnms_pkg::REG_SCORE_THR: sb.score_thr = val;
            sfnms_pkg::REG_IOU_THR:   sb.iou_thr   = val;
            default:                  sb.cls_sel   = val[0];
        endcase
    endtask

    // Offer one anchor and hold it until accepted
    task automatic send_anchor(sfnms_pkg::in_item_t it);
        int w;
        w = no_gaps ? 0 : int'($urandom_range(0, 15));
        if (w > 0) begin
            in_valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_anchor(it);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
    endtask

    // Wait for all expected results, then let the block settle
    task automatic drain();
        end_burst();
        while (sb.kept_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic sfnms_pkg::in_item_t make_anchor(bit last, int spread);
        sfnms_pkg::in_item_t it;
        logic [15:0] x, y;
        it.score_class0 = 16'($urandom);
        it.score_class1 = 16'($urandom);
        if (spread == 0) begin
            it.box_left   = 16'($urandom);
            it.box_top    = 16'($urandom);
            it.box_right  = 16'($urandom);
            it.box_bottom = 16'($urandom);
        end else begin
            // Clustered boxes so overlaps are common
            x = 16'($urandom_range(0, 2000));
            y = 16'($urandom_range(0, 2000));
            it.box_left   = 16'd30000 + x;
            it.box_top    = 16'd30000 + y;
            it.box_right  = 16'(16'd38000 + $urandom_range(0, 2000));
            it.box_bottom = 16'(16'd38000 + $urandom_range(0, 2000));
        end
        it.frame_end = last;
        return it;
    endfunction

    task automatic random_frame(int len);
        int k;
        for (k = 0; k < len; k++)
            send_anchor(make_anchor(k == len - 1, int'($urandom_range(0, 2))));
    endtask

    initial
    begin : stimulus
        sfnms_pkg::in_item_t it;
        int k, sent;
        sb = new();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        hold_off  = 0;
        no_gaps   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty frame at reset settings
        it = '0;
        it.frame_end = 1'b1;
        send_anchor(it);
        // Extremes, duplicate box, inverted box, zero-area boxes, ties
        it = '1;
        it.frame_end = 1'b0;
        send_anchor(it);
        send_anchor(it);
        it = '0;
        it.score_class1 = 16'hFFFF;
        it.box_left = 16'hFFFF; it.box_top = 16'hFFFF;
        send_anchor(it);
        send_anchor(it);
        it = '0;
        it.score_class1 = 16'h8001;
        it.box_right = 16'h1000; it.box_bottom = 16'h1000;
        send_anchor(it);
        it.box_left = 16'h0800; it.box_right = 16'h1800;
        it.score_class1 = 16'h8001;
        send_anchor(it);
        it.score_class1 = 16'h8000;
        it.frame_end = 1'b1;
        send_anchor(it);
        drain();

        // Class zero, threshold and overlap at their lows
        cfg_write(sfnms_pkg::REG_CLASS, 16'd0);
        cfg_write(sfnms_pkg::REG_SCORE_THR, 16'd0);
        cfg_write(sfnms_pkg::REG_IOU_THR, 16'd0);
        for (k = 0; k < 6; k++) begin
            it = make_anchor(k == 5, 1);
            it.score_class0 = (k == 0) ? 16'd0 : (k == 1) ? 16'd1 : it.score_class0;
            send_anchor(it);
        end
        drain();

        // Top extremes: threshold keeps nothing, overlap suppresses only identical boxes
        cfg_write(sfnms_pkg::REG_SCORE_THR, 16'hFFFF);
        cfg_write(sfnms_pkg::REG_IOU_THR, 16'hFFFF);
        random_frame(3);
        drain();
        cfg_write(sfnms_pkg::REG_SCORE_THR, 16'd0);
        random_frame(6);
        drain();

        // Overflow, then a long receiver hold-off while the next frame is offered
        cfg_write(sfnms_pkg::REG_SCORE_THR, 16'd100);
        cfg_write(sfnms_pkg::REG_IOU_THR, 16'd20000);
        hold_off = 1;
        fork
            begin
                while (sb.kept_q.size() == 0)
                    @(posedge clk);
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
            begin
                random_frame(80);
                random_frame(12);
            end
        join
        // Sender pauses until everything expected has come
        drain();

        // Random part over several settings
        sent = 0;
        while (sent < 300) begin
            if ($urandom_range(0, 1)) begin
                drain();
                case ($urandom_range(0, 3))
                    0: cfg_write(sfnms_pkg::REG_SCORE_THR, 16'($urandom));
                    1: cfg_write(sfnms_pkg::REG_IOU_THR, 16'($urandom));
                    2: cfg_write(sfnms_pkg::REG_CLASS, 16'($urandom_range(0, 1)));
                    default: cfg_write(sfnms_pkg::REG_SCORE_THR, 16'($urandom_range(0, 40000)));
                endcase
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            k = int'($urandom_range(1, 20));
            random_frame(k);
            sent += k;
        end
        drain();

        if (sb.mismatches == 0 && sb.kept_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

### sim.f
hdl/sfnms_pkg.sv
hdl/sfnms_iou.sv
hdl/score_filter_nms_core.sv
tb/tb_top.sv
